[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files of the spectrum colour map.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/spvrgb_pkg.sv]
// -----------------------------------------------------------------------------
// spvrgb_pkg
// Types and constants shared by the spectrum value to colour pipeline.
// -----------------------------------------------------------------------------
`default_nettype none

package spvrgb_pkg;

    // Field widths of the external beats.
    localparam int LEVEL_W        = 32;
    localparam int FS_W           = 32;
    localparam int CH_W           = 8;
    localparam int LEVEL_BITS_DEF = 32;

    // Full scale after reset.
    localparam logic [FS_W-1:0] FS_RESET = 32'd255;

    // Internal widths: band edges reach 400 * full_scale, ramp denominators
    // reach 70 * full_scale, and the scaled numerator reaches 255 times that.
    localparam int EDGE_W = FS_W + 9;
    localparam int DEN_W  = FS_W + 7;
    localparam int REM_W  = DEN_W + 8;
    localparam int QUO_W  = CH_W;

    // Colour band of a wavelength.
    typedef enum logic [2:0] {
        BAND_VIOLET,
        BAND_BLUE,
        BAND_CYAN,
        BAND_GREEN,
        BAND_YELLOW,
        BAND_RED,
        BAND_BLACK
    } t_band;

    // Beat payloads of the external channels.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
    } t_level_beat;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb_beat;

    typedef struct packed {
        logic [FS_W-1:0] full_scale;
    } t_cfg_beat;

    // Beats into and out of the ramp divider.
    typedef struct packed {
        t_band            band;
        logic [REM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_in;

    typedef struct packed {
        t_band            band;
        logic [QUO_W-1:0] quo;
    } t_div_out;

endpackage

`default_nettype wire

[hdl/spvrgb_stream_if.sv]
// -----------------------------------------------------------------------------
// spvrgb_stream_if
// Valid/ready channel carrying one payload beat of a chosen type.
// -----------------------------------------------------------------------------
`default_nettype none

interface spvrgb_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

[hdl/spvrgb_div.sv]
// -----------------------------------------------------------------------------
// spvrgb_div
// Pipelined restoring divider: one quotient bit per stage, eight stages,
// for a quotient known to be below 256. Carries the colour band alongside.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spvrgb_div
    import spvrgb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_div_in  i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_div_out      o_out
);

    localparam int STAGES = QUO_W;

    // Stage registers.
    logic [STAGES-1:0] r_vld;
    logic [REM_W-1:0]  r_rem  [STAGES];
    logic [DEN_W-1:0]  r_den  [STAGES];
    logic [QUO_W-1:0]  r_quo  [STAGES];
    t_band             r_band [STAGES];

    // Values presented to each stage and its next values.
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] p_vld;
    logic [REM_W-1:0]  p_rem  [STAGES];
    logic [DEN_W-1:0]  p_den  [STAGES];
    logic [QUO_W-1:0]  p_quo  [STAGES];
    t_band             p_band [STAGES];
    logic [REM_W-1:0]  n_rem  [STAGES];
    logic [QUO_W-1:0]  n_quo  [STAGES];

    // A stage takes a beat when it is empty or its successor moves on.
    always_comb begin
        rdy[STAGES] = i_out_ready;
        for (int j = STAGES - 1; j >= 0; j--) begin
            rdy[j] = !r_vld[j] || rdy[j+1];
        end
    end

    // Stage inputs: the port for the first stage, the previous stage otherwise.
    always_comb begin
        for (int j = 0; j < STAGES; j++) begin
            if (j == 0) begin
                p_vld[j]  = i_in_valid;
                p_rem[j]  = i_in.dividend;
                p_den[j]  = i_in.divisor;
                p_quo[j]  = '0;
                p_band[j] = i_in.band;
            end else begin
                p_vld[j]  = r_vld[j-1];
                p_rem[j]  = r_rem[j-1];
                p_den[j]  = r_den[j-1];
                p_quo[j]  = r_quo[j-1];
                p_band[j] = r_band[j-1];
            end
        end
    end

    // One trial subtraction of the shifted divisor per stage, MSB first.
    always_comb begin
        logic [REM_W-1:0] shifted;
        logic             ge;
        for (int j = 0; j < STAGES; j++) begin
            shifted  = REM_W'(p_den[j]) << (STAGES - 1 - j);
            ge       = (p_rem[j] >= shifted);
            n_rem[j] = ge ? (p_rem[j] - shifted) : p_rem[j];
            n_quo[j] = {p_quo[j][QUO_W-2:0], ge};
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int j = 0; j < STAGES; j++) begin
                if (rdy[j]) begin
                    r_vld[j] <= p_vld[j];
                end
            end
        end
    end

    // Payload moves with its valid bit.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < STAGES; j++) begin
            if (rdy[j] && p_vld[j]) begin
                r_rem[j]  <= n_rem[j];
                r_den[j]  <= p_den[j];
                r_quo[j]  <= n_quo[j];
                r_band[j] <= p_band[j];
            end
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[STAGES-1];
    assign o_out.band  = r_band[STAGES-1];
    assign o_out.quo   = r_quo[STAGES-1];

    // The input only blocks when every stage holds a beat.
    `ASSERT_IMPLIES(a_div_full_when_blocked, i_clk, i_rst_n, !o_in_ready, &r_vld, "divider blocked with a free stage")
    // A stalled result keeps its quotient.
    `ASSERT_NEXT(a_div_stall_holds, i_clk, i_rst_n, r_vld[STAGES-1] && !i_out_ready, r_vld[STAGES-1] && $stable(r_quo[STAGES-1]), "divider result lost under stall")

endmodule

`default_nettype wire

[hdl/spectrum_value_to_rgb_top.sv]
// -----------------------------------------------------------------------------
// spectrum_value_to_rgb_top
// Maps each level to a visible-spectrum colour between 380 and 780 nm.
//
//   Channel   Dir   Payload                      Beat taken when
//   i_level   in    level       32 bit unsigned  valid && ready
//   o_rgb     out   red, green, blue  8 bit each valid && ready
//   i_cfg     in    full_scale  32 bit unsigned  valid && ready (always ready)
//
// One level is taken per cycle while no stall holds the ready chain; the colour is
// offered once its level has passed fourteen register stages: five front stages,
// the eight-stage ramp divider and the output register, the first of which loads
// at the accepting edge. Each stage moves on when it is empty or its successor
// moves, so bubbles close up under a stall and nothing is dropped.
// Reset is synchronous; it empties every stage and sets full_scale to 255.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spectrum_value_to_rgb_top
    import spvrgb_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    spvrgb_stream_if.sink   i_level,
    spvrgb_stream_if.source o_rgb,
    spvrgb_stream_if.sink   i_cfg
);

    localparam int N_W = LEVEL_BITS + 9;

    // Band edges in units of full_scale.
    localparam int K_VIOLET = 60;
    localparam int K_BLUE   = 110;
    localparam int K_CYAN   = 130;
    localparam int K_GREEN  = 200;
    localparam int K_YELLOW = 265;
    localparam int K_TOP    = 400;

    localparam logic [CH_W-1:0] CH_FULL = '1;

    // Configuration: full_scale and its multiples, refreshed on each write.
    logic              r_fs_zero;
    logic [EDGE_W-1:0] r_e60, r_e110, r_e130, r_e200, r_e265, r_e400;
    logic [DEN_W-1:0]  r_d50, r_d20, r_d70, r_d65;
    logic [EDGE_W-1:0] cfg_fs;

    assign cfg_fs      = EDGE_W'(i_cfg.data.full_scale);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_zero <= 1'b0;
            r_e60     <= EDGE_W'(FS_RESET) * EDGE_W'(K_VIOLET);
            r_e110    <= EDGE_W'(FS_RESET) * EDGE_W'(K_BLUE);
            r_e130    <= EDGE_W'(FS_RESET) * EDGE_W'(K_CYAN);
            r_e200    <= EDGE_W'(FS_RESET) * EDGE_W'(K_GREEN);
            r_e265    <= EDGE_W'(FS_RESET) * EDGE_W'(K_YELLOW);
            r_e400    <= EDGE_W'(FS_RESET) * EDGE_W'(K_TOP);
            r_d50     <= DEN_W'(FS_RESET) * DEN_W'(K_BLUE - K_VIOLET);
            r_d20     <= DEN_W'(FS_RESET) * DEN_W'(K_CYAN - K_BLUE);
            r_d70     <= DEN_W'(FS_RESET) * DEN_W'(K_GREEN - K_CYAN);
            r_d65     <= DEN_W'(FS_RESET) * DEN_W'(K_YELLOW - K_GREEN);
        end else if (i_cfg.valid) begin
            r_fs_zero <= (i_cfg.data.full_scale == '0);
            r_e60     <= cfg_fs * EDGE_W'(K_VIOLET);
            r_e110    <= cfg_fs * EDGE_W'(K_BLUE);
            r_e130    <= cfg_fs * EDGE_W'(K_CYAN);
            r_e200    <= cfg_fs * EDGE_W'(K_GREEN);
            r_e265    <= cfg_fs * EDGE_W'(K_YELLOW);
            r_e400    <= cfg_fs * EDGE_W'(K_TOP);
            r_d50     <= DEN_W'(cfg_fs) * DEN_W'(K_BLUE - K_VIOLET);
            r_d20     <= DEN_W'(cfg_fs) * DEN_W'(K_CYAN - K_BLUE);
            r_d70     <= DEN_W'(cfg_fs) * DEN_W'(K_GREEN - K_CYAN);
            r_d65     <= DEN_W'(cfg_fs) * DEN_W'(K_YELLOW - K_GREEN);
        end
    end

    // Pipeline registers: A level, B scaled level, C band, D ramp operands,
    // E divider operands, O colour.
    logic                  r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_o_vld;
    logic [LEVEL_BITS-1:0] r_a_lvl;
    logic [N_W-1:0]        r_b_n;
    logic [EDGE_W-1:0]     r_c_n;
    t_band                 r_c_band, r_d_band, r_e_band;
    logic [DEN_W-1:0]      r_d_num, r_d_den, r_e_den;
    logic [REM_W-1:0]      r_e_x;
    t_rgb_beat             r_o_rgb;

    logic                  rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_o;
    logic                  div_in_ready, div_out_valid;
    t_div_in               div_in;
    t_div_out              div_out;

    logic [N_W-1:0]        n_b_n;
    t_band                 n_c_band;
    logic [DEN_W-1:0]      n_d_num, n_d_den;
    logic [REM_W-1:0]      n_e_x;
    t_rgb_beat             n_o_rgb;

    // Ready chain from the output back to the input.
    assign rdy_o         = !r_o_vld || o_rgb.ready;
    assign rdy_e         = !r_e_vld || div_in_ready;
    assign rdy_d         = !r_d_vld || rdy_e;
    assign rdy_c         = !r_c_vld || rdy_d;
    assign rdy_b         = !r_b_vld || rdy_c;
    assign rdy_a         = !r_a_vld || rdy_b;
    assign i_level.ready = rdy_a;

    // Stage B: 400 * level as a sum of shifts.
    assign n_b_n = (N_W'(r_a_lvl) << 8) + (N_W'(r_a_lvl) << 7) + (N_W'(r_a_lvl) << 4);

    // Stage C: pick the band from the edge compares.
    always_comb begin
        if (r_fs_zero || (EDGE_W'(r_b_n) > r_e400)) begin
            n_c_band = BAND_BLACK;
        end else if (EDGE_W'(r_b_n) < r_e60) begin
            n_c_band = BAND_VIOLET;
        end else if (EDGE_W'(r_b_n) < r_e110) begin
            n_c_band = BAND_BLUE;
        end else if (EDGE_W'(r_b_n) < r_e130) begin
            n_c_band = BAND_CYAN;
        end else if (EDGE_W'(r_b_n) < r_e200) begin
            n_c_band = BAND_GREEN;
        end else if (EDGE_W'(r_b_n) < r_e265) begin
            n_c_band = BAND_YELLOW;
        end else begin
            n_c_band = BAND_RED;
        end
    end

    // Stage D: ramp numerator and denominator; flat bands divide zero by one.
    always_comb begin
        unique case (r_c_band)
            BAND_VIOLET: begin
                n_d_num = DEN_W'(r_e60 - r_c_n);
                n_d_den = DEN_W'(r_e60);
            end
            BAND_BLUE: begin
                n_d_num = DEN_W'(r_c_n - r_e60);
                n_d_den = r_d50;
            end
            BAND_CYAN: begin
                n_d_num = DEN_W'(r_e130 - r_c_n);
                n_d_den = r_d20;
            end
            BAND_GREEN: begin
                n_d_num = DEN_W'(r_c_n - r_e130);
                n_d_den = r_d70;
            end
            BAND_YELLOW: begin
                n_d_num = DEN_W'(r_e265 - r_c_n);
                n_d_den = r_d65;
            end
            default: begin
                n_d_num = '0;
                n_d_den = DEN_W'(1);
            end
        endcase
    end

    // Stage E: scale the numerator by 255.
    assign n_e_x = (REM_W'(r_d_num) << 8) - REM_W'(r_d_num);

    // Valid bits of the front stages and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (rdy_a) r_a_vld <= i_level.valid;
            if (rdy_b) r_b_vld <= r_a_vld;
            if (rdy_c) r_c_vld <= r_b_vld;
            if (rdy_d) r_d_vld <= r_c_vld;
            if (rdy_e) r_e_vld <= r_d_vld;
            if (rdy_o) r_o_vld <= div_out_valid;
        end
    end

    // Payload of the front stages and the output register.
    always_ff @(posedge i_clk) begin
        if (rdy_a && i_level.valid) begin
            r_a_lvl <= i_level.data.level[LEVEL_BITS-1:0];
        end
        if (rdy_b && r_a_vld) begin
            r_b_n <= n_b_n;
        end
        if (rdy_c && r_b_vld) begin
            r_c_n    <= EDGE_W'(r_b_n);
            r_c_band <= n_c_band;
        end
        if (rdy_d && r_c_vld) begin
            r_d_band <= r_c_band;
            r_d_num  <= n_d_num;
            r_d_den  <= n_d_den;
        end
        if (rdy_e && r_d_vld) begin
            r_e_band <= r_d_band;
            r_e_x    <= n_e_x;
            r_e_den  <= r_d_den;
        end
        if (rdy_o && div_out_valid) begin
            r_o_rgb <= n_o_rgb;
        end
    end

    // Ramp divider.
    assign div_in.band     = r_e_band;
    assign div_in.dividend = r_e_x;
    assign div_in.divisor  = r_e_den;

    spvrgb_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_e_vld),
        .o_in_ready  (div_in_ready),
        .i_in        (div_in),
        .o_out_valid (div_out_valid),
        .i_out_ready (rdy_o),
        .o_out       (div_out)
    );

    // Colour assembly: the ramp goes to the band's moving channel.
    always_comb begin
        n_o_rgb = '0;
        unique case (div_out.band)
            BAND_VIOLET: begin
                n_o_rgb.red  = div_out.quo;
                n_o_rgb.blue = CH_FULL;
            end
            BAND_BLUE: begin
                n_o_rgb.green = div_out.quo;
                n_o_rgb.blue  = CH_FULL;
            end
            BAND_CYAN: begin
                n_o_rgb.green = CH_FULL;
                n_o_rgb.blue  = div_out.quo;
            end
            BAND_GREEN: begin
                n_o_rgb.red   = div_out.quo;
                n_o_rgb.green = CH_FULL;
            end
            BAND_YELLOW: begin
                n_o_rgb.red   = CH_FULL;
                n_o_rgb.green = div_out.quo;
            end
            BAND_RED: begin
                n_o_rgb.red = CH_FULL;
            end
            default: begin
                n_o_rgb = '0;
            end
        endcase
    end

    assign o_rgb.valid = r_o_vld;
    assign o_rgb.data  = r_o_rgb;

    // An accepted level always lands in the first stage.
    `ASSERT_NEXT(a_top_accept_lands, i_clk, i_rst_n, i_level.valid && rdy_a, r_a_vld, "accepted level not captured")
    // Every spectrum colour leaves at least one channel dark.
    `ASSERT_IMPLIES(a_top_one_channel_dark, i_clk, i_rst_n, r_o_vld, (r_o_rgb.red == '0) || (r_o_rgb.green == '0) || (r_o_rgb.blue == '0), "colour with no dark channel")

endmodule

`default_nettype wire
